// ===== hdl/agrd_pkg.sv =====
// Package for the anti-aliased glyph run decoder.
// Holds the channel word types, register and shade codes, and the controller types.
// No dependencies; compiled first.
`default_nettype none

package agrd_pkg;

    localparam int ROW_W             = 10;
    localparam int COL_W             = 10;
    localparam int END_W             = 11;
    localparam int RUN_W             = 6;
    localparam int COLOR_W           = 16;
    localparam int CODE_W            = 8;
    localparam int CFG_INDEX_W       = 3;
    localparam int ROW_SPAN          = 1 << ROW_W;
    localparam int SCREEN_WIDTH_DEF  = 1024;

    localparam logic [COLOR_W-1:0] FOREGROUND_RESET = 16'hFFFF;
    localparam logic [COLOR_W-1:0] HALF_RESET       = 16'h8410;
    localparam logic [COLOR_W-1:0] QUARTER_RESET    = 16'h4208;
    localparam logic [COLOR_W-1:0] BACKGROUND_RESET = 16'h0000;
    localparam logic [COL_W-1:0]   BOX_LEFT_RESET   = 10'd0;
    localparam logic [END_W-1:0]   BOX_END_RESET    = 11'd1024;
    localparam logic [COL_W-1:0]   GLYPH_LEFT_RESET = 10'd0;
    localparam logic [COL_W-1:0]   GLYPH_WIDTH_RESET = 10'd16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FOREGROUND  = 3'd0,
        CFG_HALF        = 3'd1,
        CFG_QUARTER     = 3'd2,
        CFG_BACKGROUND  = 3'd3,
        CFG_BOX_LEFT    = 3'd4,
        CFG_BOX_END     = 3'd5,
        CFG_GLYPH_LEFT  = 3'd6,
        CFG_GLYPH_WIDTH = 3'd7
    } cfg_index_t;

    typedef enum logic [1:0] {
        SHADE_BACKGROUND = 2'd0,
        SHADE_QUARTER    = 2'd1,
        SHADE_HALF       = 2'd2,
        SHADE_FULL       = 2'd3
    } shade_t;

    typedef struct packed {
        logic [CODE_W-1:0] code_byte;
        logic              new_glyph;
        logic [ROW_W-1:0]  target_row;
    } code_word_t;

    typedef struct packed {
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   column;
        logic [RUN_W-1:0]   run_length;
        logic [COLOR_W-1:0] color;
        logic               write_enable;
        logic               last;
    } pixel_run_t;

    typedef struct packed {
        logic [CFG_INDEX_W-1:0] index;
        logic [COLOR_W-1:0]     data;
    } cfg_word_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } agrd_state_t;

    typedef struct packed {
        logic load;
        logic step;
    } agrd_cmd_t;

    typedef struct packed {
        logic width_zero;
        logic out_busy;
        logic seg_last;
    } agrd_status_t;

endpackage

`default_nettype wire

// ===== hdl/agrd_stream_if.sv =====
// Valid/ready channel interface used for code words, run words and configuration words.
// The payload type comes from agrd_pkg through the type parameter.
`default_nettype none

interface agrd_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hdl/agrd_ctrl.sv =====
// Controller of the glyph run decoder: takes code words and sequences segments.
// Depends on agrd_pkg for the state, command and status types.
`default_nettype none

module agrd_ctrl
    import agrd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         code_valid,
    output logic              code_ready,
    input  wire agrd_status_t status,
    output agrd_cmd_t         cmd
);

    agrd_state_t state_reg;
    agrd_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (code_valid && !status.width_zero)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (!status.out_busy && status.seg_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        code_ready = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                code_ready = 1'b1;
                cmd.load   = code_valid;
            end
            ST_RUN:
            begin
                cmd.step = !status.out_busy;
            end
            default:
            begin
                code_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A code word with a nonzero glyph width always starts a segment sequence.
    a_load_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && !status.width_zero) |=> (state_reg == ST_RUN))
        else $error("code word did not start a segment sequence");

    // No new code word is taken while segments are still being produced.
    a_no_load_while_step: assert property (@(posedge clk) disable iff (!rst_n)
        !(code_ready && cmd.step))
        else $error("code word accepted during segment sequence");

    // The final segment of a code word returns the controller to idle.
    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && status.seg_last) |=> (state_reg == ST_IDLE))
        else $error("sequence did not end after last segment");

endmodule

`default_nettype wire

// ===== hdl/agrd_datapath.sv =====
// Datapath of the glyph run decoder: palette and box registers, row/column state,
// one row segment per step, and the output word register. Depends on agrd_pkg and agrd_stream_if.
`default_nettype none

module agrd_datapath
    import agrd_pkg::*;
#(
    parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF
)(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire code_word_t code,
    input  wire agrd_cmd_t  cmd,
    output agrd_status_t    status,
    agrd_stream_if.source   runs,
    agrd_stream_if.sink     cfg
);

    // Rows wrap at the screen size; the wrap is a short restoring reduction.
    localparam int QBITS = (SCREEN_WIDTH > ROW_SPAN) ? 1
                         : $clog2(ROW_SPAN / SCREEN_WIDTH + 1);
    localparam int MW    = $clog2(SCREEN_WIDTH) + QBITS + 1;

    function automatic logic [ROW_W-1:0] wrap_row(input logic [ROW_W:0] v);
        logic [MW-1:0] r;
        r = MW'(v);
        for (int k = QBITS - 1; k >= 0; k--)
        begin
            if (r >= (MW'(SCREEN_WIDTH) << k))
            begin
                r = r - (MW'(SCREEN_WIDTH) << k);
            end
        end
        return r[ROW_W-1:0];
    endfunction

    logic [COLOR_W-1:0] fg_reg, half_reg, quarter_reg, bg_reg;
    logic [COLOR_W-1:0] fg_next, half_next, quarter_next, bg_next;
    logic [COL_W-1:0]   box_left_reg, glyph_left_reg, glyph_width_reg;
    logic [COL_W-1:0]   box_left_next, glyph_left_next, glyph_width_next;
    logic [END_W-1:0]   box_end_reg, box_end_next;

    logic [COL_W-1:0]   lpl_reg, skip_reg, wcol_reg;
    logic [COL_W-1:0]   lpl_next, skip_next, wcol_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    shade_t             shade_reg, shade_next;
    logic [RUN_W-1:0]   num_reg, num_next;

    pixel_run_t         out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    logic               left_ok;
    logic [COL_W-1:0]   start_wcol, start_skip;
    logic [RUN_W-1:0]   seg_expected, seg_cut, seg_pre, seg_actual, num_after;
    logic [END_W-1:0]   seg_end, wcol_ext;
    logic [COL_W-1:0]   lpl_after;
    logic [COLOR_W-1:0] seg_color;
    logic               suppress, seg_we;

    assign cfg.ready  = 1'b1;
    assign runs.valid = out_valid_reg;
    assign runs.payload = out_reg;

    assign status.width_zero = (glyph_width_reg == '0);
    assign status.out_busy   = out_valid_reg && !runs.ready;
    assign status.seg_last   = (num_after == '0);

    // Row setup: start at the glyph, or at the box edge with a left skip.
    assign left_ok    = (glyph_left_reg >= box_left_reg);
    assign start_wcol = left_ok ? glyph_left_reg : box_left_reg;
    assign start_skip = left_ok ? '0 : (box_left_reg - glyph_left_reg);

    // One row segment of the current run.
    always_comb
    begin
        seg_expected = ({{(COL_W-RUN_W){1'b0}}, num_reg} < lpl_reg) ? num_reg
                                                                     : lpl_reg[RUN_W-1:0];
        seg_cut      = ({{(COL_W-RUN_W){1'b0}}, seg_expected} < skip_reg) ? seg_expected
                                                                           : skip_reg[RUN_W-1:0];
        seg_pre      = seg_expected - seg_cut;
        wcol_ext     = {1'b0, wcol_reg};
        seg_end      = wcol_ext + END_W'(seg_pre);
        seg_actual   = seg_pre;
        if (seg_end >= box_end_reg)
        begin
            seg_actual = (box_end_reg > wcol_ext) ? RUN_W'(box_end_reg - wcol_ext) : '0;
        end
        num_after = num_reg - seg_expected;
        lpl_after = lpl_reg - COL_W'(seg_expected);
    end

    always_comb
    begin
        suppress = 1'b0;
        case (shade_reg)
            SHADE_FULL:    seg_color = fg_reg;
            SHADE_HALF:    seg_color = half_reg;
            SHADE_QUARTER: seg_color = quarter_reg;
            default:
            begin
                seg_color = bg_reg;
                suppress  = (bg_reg == fg_reg);
            end
        endcase
        seg_we = (seg_actual != '0) && !suppress;
    end

    // Configuration writes.
    always_comb
    begin
        fg_next          = fg_reg;
        half_next        = half_reg;
        quarter_next     = quarter_reg;
        bg_next          = bg_reg;
        box_left_next    = box_left_reg;
        box_end_next     = box_end_reg;
        glyph_left_next  = glyph_left_reg;
        glyph_width_next = glyph_width_reg;
        if (cfg.valid)
        begin
            case (cfg_index_t'(cfg.payload.index))
                CFG_FOREGROUND:  fg_next          = cfg.payload.data;
                CFG_HALF:        half_next        = cfg.payload.data;
                CFG_QUARTER:     quarter_next     = cfg.payload.data;
                CFG_BACKGROUND:  bg_next          = cfg.payload.data;
                CFG_BOX_LEFT:    box_left_next    = cfg.payload.data[COL_W-1:0];
                CFG_BOX_END:     box_end_next     = cfg.payload.data[END_W-1:0];
                CFG_GLYPH_LEFT:  glyph_left_next  = cfg.payload.data[COL_W-1:0];
                CFG_GLYPH_WIDTH: glyph_width_next = cfg.payload.data[COL_W-1:0];
                default:         fg_next          = fg_reg;
            endcase
        end
    end

    // Decode state and output word.
    always_comb
    begin
        lpl_next       = lpl_reg;
        skip_next      = skip_reg;
        wcol_next      = wcol_reg;
        row_next       = row_reg;
        shade_next     = shade_reg;
        num_next       = num_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !runs.ready;
        if (cmd.load)
        begin
            shade_next = shade_t'(code.code_byte[CODE_W-1:CODE_W-2]);
            num_next   = code.code_byte[RUN_W-1:0];
            if (code.new_glyph)
            begin
                row_next = code.target_row;
            end
            if (code.new_glyph || (!status.width_zero && lpl_reg == '0))
            begin
                lpl_next  = glyph_width_reg;
                wcol_next = start_wcol;
                skip_next = start_skip;
            end
        end
        else if (cmd.step)
        begin
            out_next.row          = row_reg;
            out_next.column       = wcol_reg;
            out_next.run_length   = seg_we ? seg_actual : '0;
            out_next.color        = seg_color;
            out_next.write_enable = seg_we;
            out_next.last         = (num_after == '0);
            out_valid_next        = 1'b1;
            num_next  = num_after;
            skip_next = skip_reg - COL_W'(seg_cut);
            wcol_next = wcol_reg + COL_W'(seg_actual);
            lpl_next  = lpl_after;
            if (lpl_after == '0)
            begin
                row_next  = wrap_row({1'b0, row_reg} + 1'b1);
                lpl_next  = glyph_width_reg;
                wcol_next = start_wcol;
                skip_next = start_skip;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg          <= FOREGROUND_RESET;
            half_reg        <= HALF_RESET;
            quarter_reg     <= QUARTER_RESET;
            bg_reg          <= BACKGROUND_RESET;
            box_left_reg    <= BOX_LEFT_RESET;
            box_end_reg     <= BOX_END_RESET;
            glyph_left_reg  <= GLYPH_LEFT_RESET;
            glyph_width_reg <= GLYPH_WIDTH_RESET;
            lpl_reg         <= '0;
            skip_reg        <= '0;
            wcol_reg        <= '0;
            row_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            fg_reg          <= fg_next;
            half_reg        <= half_next;
            quarter_reg     <= quarter_next;
            bg_reg          <= bg_next;
            box_left_reg    <= box_left_next;
            box_end_reg     <= box_end_next;
            glyph_left_reg  <= glyph_left_next;
            glyph_width_reg <= glyph_width_next;
            lpl_reg         <= lpl_next;
            skip_reg        <= skip_next;
            wcol_reg        <= wcol_next;
            row_reg         <= row_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shade_reg <= shade_next;
        num_reg   <= num_next;
        out_reg   <= out_next;
    end

    // Every step leaves a word in the output register.
    a_step_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |=> out_valid_reg)
        else $error("segment step did not produce an output word");

    // A word that writes nothing carries a zero length.
    a_empty_has_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.write_enable) |-> (out_reg.run_length == '0))
        else $error("non-writing word with nonzero length");

    // A set up row always has glyph pixels left while segments are produced.
    a_row_set_up: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (lpl_reg != '0))
        else $error("segment step without a set up row");

endmodule

`default_nettype wire

// ===== hdl/antialiased_glyph_run_decoder_core.sv =====
// Anti-aliased glyph run decoder: top level joining the controller and the datapath.
// Depends on agrd_pkg, agrd_stream_if, agrd_ctrl and agrd_datapath.
//
// Each code word carries one run-length byte (2-bit shade, 6-bit run) of a glyph
// bitmap, plus a new-glyph flag and the screen row of the glyph's first row. The
// block cuts the run at the glyph width, clips every row piece against the text box,
// and sends one run word per row piece on the runs channel: row, first column,
// clipped length, palette color and a write enable; the final word of a code byte
// has last set. A zero run length gives one empty word. A zero glyph width drops the
// code byte and sends nothing. Background runs are sent with write_enable low when
// the background color equals the foreground color. Once a code word is taken, the
// datapath produces one row piece per cycle into its output register whenever the
// runs channel is not stalled. The next code word is taken once the last run word
// of the previous one has been loaded into the output register. The eight palette
// and box registers are written on the cfg channel, which is always ready; write
// them only while the block is idle. Rows wrap at SCREEN_WIDTH.
`default_nettype none

module antialiased_glyph_run_decoder_core
    import agrd_pkg::*;
#(
    parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF
)(
    input  wire logic     clk,
    input  wire logic     rst_n,
    agrd_stream_if.sink   codes,
    agrd_stream_if.source runs,
    agrd_stream_if.sink   cfg
);

    agrd_cmd_t    cmd;
    agrd_status_t status;

    // The controller owns the code handshake; the datapath sees only its payload.
    agrd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .code_valid (codes.valid),
        .code_ready (codes.ready),
        .status     (status),
        .cmd        (cmd)
    );

    agrd_datapath #(
        .SCREEN_WIDTH (SCREEN_WIDTH)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .code   (codes.payload),
        .cmd    (cmd),
        .status (status),
        .runs   (runs),
        .cfg    (cfg)
    );

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking bench for antialiased_glyph_run_decoder_core: a directed table, then random phases.
// Needs agrd_pkg and agrd_stream_if from hdl; results are checked against a predictor held here.
`timescale 1ns / 100ps

module tb;
    import agrd_pkg::*;

    // Generous ceiling: every code word could give 63 run words, each held up by the
    // longest receiver stall, plus the longest sender gap and the settling pauses.
    localparam int LIMIT_CYCLES    = 1_000_000;
    // Cycles left after the last run word before a register write or the final verdict.
    // A code word dropped by a zero glyph width gives no word, so this wait also covers it.
    localparam int SETTLE_CYCLES   = 8;
    localparam int MAX_PIECES      = 63;
    localparam int PHASES          = 8;
    localparam int CODES_PER_PHASE = 17;

    // One row of the directed table: either a register write or a code word. A code word
    // with a typed result gives exactly one run word, written out by hand.
    typedef struct {
        bit          is_reg;
        cfg_index_t  reg_index;
        logic [15:0] reg_data;
        code_word_t  code;
        bit          known;
        pixel_run_t  result;
    } step_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    agrd_stream_if #(.payload_t(code_word_t)) code_ch ();
    agrd_stream_if #(.payload_t(pixel_run_t)) run_ch ();
    agrd_stream_if #(.payload_t(cfg_word_t))  reg_ch ();

    antialiased_glyph_run_decoder_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .codes (code_ch),
        .runs  (run_ch),
        .cfg   (reg_ch)
    );

    always #2 clk = ~clk;

    // Palette and box registers as the bench believes the block holds them.
    logic [15:0] pal_fg, pal_half, pal_quarter, pal_bg;
    logic [9:0]  m_box_left, m_glyph_left, m_glyph_width;
    logic [10:0] m_box_end;

    // Decoder position: pixels still due in this glyph row, pixels still to drop on the
    // left, the next screen column and the screen row being decoded.
    logic [9:0]  row_pixels_left, skip_left, next_column, glyph_row;

    // Run words owed by the block, oldest first.
    pixel_run_t  expected_runs[$];

    bit          calm = 1'b0;
    int unsigned stall_left = 0;
    int          cycles = 0;
    int          mismatches = 0;
    int          codes_sent = 0;
    int          runs_checked = 0;
    int          reg_writes = 0;

    // Gap length for either side. Most gaps are zero or short, a few are long, and in a
    // calm phase there are none at all.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // A glyph row starts at the glyph's own left edge when that is inside the box;
    // otherwise it starts at the box edge and drops the pixels that stick out.
    function automatic void open_row();
        row_pixels_left = m_glyph_width;
        if (m_glyph_left >= m_box_left)
        begin
            next_column = m_glyph_left;
            skip_left   = '0;
        end
        else
        begin
            next_column = m_box_left;
            skip_left   = m_box_left - m_glyph_left;
        end
    endfunction

    // Works out the run words that one code byte causes and advances the position.
    function automatic void decode_code(input code_word_t w, ref pixel_run_t pieces[$]);
        shade_t      shade;
        logic [15:0] color;
        bit          mute;
        int          remaining, span, shown, cut, count;
        pixel_run_t  piece;
        shade     = shade_t'(w.code_byte[7:6]);
        remaining = int'(w.code_byte[5:0]);
        mute      = 1'b0;
        count     = 0;
        if (w.new_glyph)
        begin
            glyph_row = w.target_row;
            open_row();
        end
        // A zero-width glyph swallows the byte without a word.
        if (m_glyph_width == '0)
            return;
        if (row_pixels_left == '0)
            open_row();
        case (shade)
            SHADE_FULL:    color = pal_fg;
            SHADE_HALF:    color = pal_half;
            SHADE_QUARTER: color = pal_quarter;
            default:
            begin
                color = pal_bg;
                mute  = (pal_bg == pal_fg);
            end
        endcase
        do
        begin
            // The run is cut at the end of the glyph row, then clipped on both sides.
            span      = (remaining < int'(row_pixels_left)) ? remaining : int'(row_pixels_left);
            cut       = (span < int'(skip_left)) ? span : int'(skip_left);
            shown     = span - cut;
            skip_left = skip_left - 10'(cut);
            if (int'(next_column) + shown >= int'(m_box_end))
                shown = (int'(m_box_end) > int'(next_column)) ?
                        int'(m_box_end) - int'(next_column) : 0;
            remaining       = remaining - span;
            row_pixels_left = row_pixels_left - 10'(span);

            piece.row          = glyph_row;
            piece.column       = next_column;
            piece.write_enable = (shown > 0) && !mute;
            piece.run_length   = piece.write_enable ? 6'(shown) : '0;
            piece.color        = color;
            count++;
            piece.last         = !(remaining > 0 && count < MAX_PIECES);
            pieces.push_back(piece);

            // A suppressed background run still moves the column on.
            next_column = 10'(int'(next_column) + shown);
            if (row_pixels_left == '0)
            begin
                glyph_row = 10'((int'(glyph_row) + 1) % SCREEN_WIDTH_DEF);
                open_row();
            end
        end
        while (remaining > 0 && count < MAX_PIECES);
    endfunction

    function automatic step_row_t code_step(logic [7:0] code, logic fresh, logic [9:0] first_row);
        step_row_t s;
        s.is_reg    = 1'b0;
        s.reg_index = CFG_FOREGROUND;
        s.reg_data  = '0;
        s.code      = '{code_byte: code, new_glyph: fresh, target_row: first_row};
        s.known     = 1'b0;
        s.result    = '0;
        return s;
    endfunction

    function automatic step_row_t reg_step(cfg_index_t idx, logic [15:0] data);
        step_row_t s;
        s           = code_step('0, 1'b0, '0);
        s.is_reg    = 1'b1;
        s.reg_index = idx;
        s.reg_data  = data;
        return s;
    endfunction

    function automatic step_row_t known_step(logic [7:0] code, logic fresh, logic [9:0] first_row,
                                             logic [9:0] r, logic [9:0] c, logic [5:0] len,
                                             logic [15:0] color, logic we);
        step_row_t s;
        s        = code_step(code, fresh, first_row);
        s.known  = 1'b1;
        s.result = '{row: r, column: c, run_length: len, color: color,
                     write_enable: we, last: 1'b1};
        return s;
    endfunction

    // Waits for every owed run word, then lets the block settle so that a register
    // write never lands while a code word is still being worked on.
    task automatic quiesce();
        code_ch.valid <= 1'b0;
        while (expected_runs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes one register word and mirrors it once the handshake has gone through.
    // Valid stays high so that writes can follow back to back; the next code word lowers it.
    task automatic write_reg(input cfg_index_t idx, input logic [15:0] data);
        reg_ch.valid   <= 1'b1;
        reg_ch.payload <= '{index: idx, data: data};
        do
            @(posedge clk);
        while (!reg_ch.ready);
        case (idx)
            CFG_FOREGROUND:  pal_fg        = data;
            CFG_HALF:        pal_half      = data;
            CFG_QUARTER:     pal_quarter   = data;
            CFG_BACKGROUND:  pal_bg        = data;
            CFG_BOX_LEFT:    m_box_left    = data[9:0];
            CFG_BOX_END:     m_box_end     = data[10:0];
            CFG_GLYPH_LEFT:  m_glyph_left  = data[9:0];
            CFG_GLYPH_WIDTH: m_glyph_width = data[9:0];
            default:         ;
        endcase
        reg_writes++;
    endtask

    // Sends one code word after a random gap and books the run words it owes. Valid is
    // lowered only before a gap or by quiesce, so back-to-back words keep it high.
    task automatic send_code(input code_word_t w, input bit known, input pixel_run_t known_run);
        int unsigned gap;
        pixel_run_t  predicted[$];
        gap = pick_gap();
        reg_ch.valid <= 1'b0;
        if (gap > 0)
        begin
            code_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        code_ch.valid   <= 1'b1;
        code_ch.payload <= w;
        do
            @(posedge clk);
        while (!code_ch.ready);
        decode_code(w, predicted);
        if (known)
            expected_runs.push_back(known_run);
        else
            foreach (predicted[i])
                expected_runs.push_back(predicted[i]);
        codes_sent++;
    endtask

    // Receiver: ready drops for random stretches, long ones now and then.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            run_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else
        begin
            run_ch.ready <= 1'b1;
            stall_left   <= pick_gap();
        end
    end

    // Every accepted run word is compared field by field with the oldest one owed.
    always @(posedge clk)
    begin : run_check
        pixel_run_t want, got;
        bit         bad;
        if (rst_n && run_ch.valid && run_ch.ready)
        begin
            got = run_ch.payload;
            runs_checked++;
            if (expected_runs.size() == 0)
            begin
                $error("unexpected run word: row %0d column %0d run_length %0d",
                       got.row, got.column, got.run_length);
                mismatches++;
            end
            else
            begin
                want = expected_runs.pop_front();
                bad  = 1'b0;
                if (got.row !== want.row)
                begin
                    $error("row: expected %0d, got %0d", want.row, got.row);
                    bad = 1'b1;
                end
                if (got.column !== want.column)
                begin
                    $error("column: expected %0d, got %0d", want.column, got.column);
                    bad = 1'b1;
                end
                if (got.run_length !== want.run_length)
                begin
                    $error("run_length: expected %0d, got %0d", want.run_length, got.run_length);
                    bad = 1'b1;
                end
                if (got.color !== want.color)
                begin
                    $error("color: expected %04h, got %04h", want.color, got.color);
                    bad = 1'b1;
                end
                if (got.write_enable !== want.write_enable)
                begin
                    $error("write_enable: expected %0b, got %0b",
                           want.write_enable, got.write_enable);
                    bad = 1'b1;
                end
                if (got.last !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, got.last);
                    bad = 1'b1;
                end
                if (bad)
                    mismatches++;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d run words still owed",
                     cycles, expected_runs.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        step_row_t   plan[$];
        bit          after_reg;
        int          directed_codes;
        int unsigned r;
        logic [15:0] fg;
        code_word_t  w;

        code_ch.valid   = 1'b0;
        code_ch.payload = '0;
        reg_ch.valid    = 1'b0;
        reg_ch.payload  = '0;
        run_ch.ready    = 1'b0;

        // Register values and decoder position right after reset.
        pal_fg          = FOREGROUND_RESET;
        pal_half        = HALF_RESET;
        pal_quarter     = QUARTER_RESET;
        pal_bg          = BACKGROUND_RESET;
        m_box_left      = BOX_LEFT_RESET;
        m_box_end       = BOX_END_RESET;
        m_glyph_left    = GLYPH_LEFT_RESET;
        m_glyph_width   = GLYPH_WIDTH_RESET;
        row_pixels_left = '0;
        skip_left       = '0;
        next_column     = '0;
        glyph_row       = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset palette, full-width box, 16-pixel glyph. Nothing is set up yet, so the
        // first byte opens row 0 at column 0.
        plan.push_back(known_step({SHADE_FULL, 6'd5}, 1'b0, 10'd0,
                                  10'd0, 10'd0, 6'd5, FOREGROUND_RESET, 1'b1));
        plan.push_back(known_step({SHADE_HALF, 6'd3}, 1'b0, 10'd0,
                                  10'd0, 10'd5, 6'd3, HALF_RESET, 1'b1));
        // A zero run gives one empty word.
        plan.push_back(known_step({SHADE_QUARTER, 6'd0}, 1'b0, 10'd0,
                                  10'd0, 10'd8, 6'd0, QUARTER_RESET, 1'b0));
        // Background differs from foreground, so it is drawn; this closes row 0.
        plan.push_back(known_step({SHADE_BACKGROUND, 6'd8}, 1'b0, 10'd0,
                                  10'd0, 10'd8, 6'd8, BACKGROUND_RESET, 1'b1));
        // The longest run spans four glyph rows.
        plan.push_back(code_step({SHADE_FULL, 6'd63}, 1'b0, 10'd0));
        // A new glyph on the last screen row; the row number then wraps to zero.
        plan.push_back(known_step({SHADE_FULL, 6'd16}, 1'b1, 10'd1023,
                                  10'd1023, 10'd0, 6'd16, FOREGROUND_RESET, 1'b1));
        plan.push_back(known_step({SHADE_BACKGROUND, 6'd0}, 1'b1, 10'd0,
                                  10'd0, 10'd0, 6'd0, BACKGROUND_RESET, 1'b0));
        plan.push_back(code_step({SHADE_BACKGROUND, 6'd63}, 1'b0, 10'd0));

        // Background equal to foreground: suppressed, but the column still moves.
        plan.push_back(reg_step(CFG_BACKGROUND, 16'hFFFF));
        plan.push_back(known_step({SHADE_BACKGROUND, 6'd4}, 1'b1, 10'd5,
                                  10'd5, 10'd0, 6'd0, 16'hFFFF, 1'b0));
        plan.push_back(code_step({SHADE_FULL, 6'd2}, 1'b0, 10'd0));

        // Palette at its extremes.
        plan.push_back(reg_step(CFG_FOREGROUND, 16'h0000));
        plan.push_back(reg_step(CFG_HALF, 16'hFFFF));
        plan.push_back(reg_step(CFG_QUARTER, 16'h0000));
        plan.push_back(known_step({SHADE_HALF, 6'd1}, 1'b1, 10'd7,
                                  10'd7, 10'd0, 6'd1, 16'hFFFF, 1'b1));
        plan.push_back(known_step({SHADE_QUARTER, 6'd1}, 1'b0, 10'd0,
                                  10'd7, 10'd1, 6'd1, 16'h0000, 1'b1));

        // Glyph starts left of the box and runs past its right edge.
        plan.push_back(reg_step(CFG_BOX_LEFT, 16'd20));
        plan.push_back(reg_step(CFG_GLYPH_LEFT, 16'd10));
        plan.push_back(reg_step(CFG_BOX_END, 16'd30));
        plan.push_back(reg_step(CFG_GLYPH_WIDTH, 16'd40));
        plan.push_back(code_step({SHADE_FULL, 6'd35}, 1'b1, 10'd100));
        plan.push_back(code_step({SHADE_HALF, 6'd63}, 1'b1, 10'd100));

        // Glyph near the right screen edge: clipped at the box end, column wraps.
        plan.push_back(reg_step(CFG_GLYPH_LEFT, 16'd1000));
        plan.push_back(reg_step(CFG_BOX_LEFT, 16'd0));
        plan.push_back(reg_step(CFG_BOX_END, 16'd1024));
        plan.push_back(code_step({SHADE_FULL, 6'd30}, 1'b1, 10'd200));
        plan.push_back(code_step({SHADE_QUARTER, 6'd10}, 1'b0, 10'd0));

        // One-pixel glyph in the last column: a long run gives the most words.
        plan.push_back(reg_step(CFG_GLYPH_WIDTH, 16'd1));
        plan.push_back(reg_step(CFG_GLYPH_LEFT, 16'd1023));
        plan.push_back(code_step({SHADE_FULL, 6'd63}, 1'b1, 10'd1000));
        // Box end at zero clips everything away.
        plan.push_back(reg_step(CFG_BOX_END, 16'd0));
        plan.push_back(code_step({SHADE_FULL, 6'd3}, 1'b1, 10'd3));

        // Zero width: bytes are dropped, with or without a new glyph.
        plan.push_back(reg_step(CFG_GLYPH_WIDTH, 16'd0));
        plan.push_back(code_step({SHADE_FULL, 6'd63}, 1'b0, 10'd0));
        plan.push_back(code_step({SHADE_BACKGROUND, 6'd1}, 1'b1, 10'd9));

        // Widest glyph with the box start at its maximum: the whole run is skipped.
        plan.push_back(reg_step(CFG_GLYPH_WIDTH, 16'd1023));
        plan.push_back(reg_step(CFG_BOX_LEFT, 16'd1023));
        plan.push_back(reg_step(CFG_GLYPH_LEFT, 16'd0));
        plan.push_back(reg_step(CFG_BOX_END, 16'd1024));
        plan.push_back(known_step({SHADE_FULL, 6'd63}, 1'b1, 10'd512,
                                  10'd512, 10'd1023, 6'd0, 16'h0000, 1'b0));
        plan.push_back(code_step({SHADE_HALF, 6'd63}, 1'b0, 10'd0));

        after_reg = 1'b0;
        foreach (plan[i])
        begin
            if (plan[i].is_reg)
            begin
                if (!after_reg)
                    quiesce();
                write_reg(plan[i].reg_index, plan[i].reg_data);
                after_reg = 1'b1;
            end
            else
            begin
                send_code(plan[i].code, plan[i].known, plan[i].result);
                after_reg = 1'b0;
            end
        end
        directed_codes = codes_sent;

        // Random phases: a fresh setting of every register, then glyphs made of random
        // bytes. Widths lean small so rows wrap often; extremes turn up now and then.
        for (int p = 0; p < PHASES; p++)
        begin
            quiesce();
            calm = ($urandom_range(0, 3) == 0);
            fg   = 16'($urandom);
            write_reg(CFG_FOREGROUND, fg);
            write_reg(CFG_HALF, 16'($urandom));
            write_reg(CFG_QUARTER, 16'($urandom));
            write_reg(CFG_BACKGROUND, ($urandom_range(0, 3) == 0) ? fg : 16'($urandom));

            r = $urandom_range(0, 99);
            write_reg(CFG_BOX_LEFT, (r < 50) ? 16'd0 : (r < 60) ? 16'd1023 :
                                    (r < 85) ? 16'($urandom_range(0, 63)) :
                                    16'($urandom_range(0, 1023)));
            r = $urandom_range(0, 99);
            write_reg(CFG_GLYPH_LEFT, (r < 20) ? 16'd0 : (r < 30) ? 16'd1023 :
                                      (r < 70) ? 16'($urandom_range(0, 63)) :
                                      16'($urandom_range(0, 1023)));
            r = $urandom_range(0, 99);
            write_reg(CFG_BOX_END, (r < 35) ? 16'd1024 : (r < 45) ? 16'd0 :
                                   16'($urandom_range(0, 1024)));
            r = $urandom_range(0, 99);
            write_reg(CFG_GLYPH_WIDTH, (r < 8) ? 16'd0 : (r < 16) ? 16'd1023 :
                                       (r < 30) ? 16'd1 : 16'($urandom_range(2, 48)));

            for (int k = 0; k < CODES_PER_PHASE; k++)
            begin
                w.code_byte  = 8'($urandom_range(0, 255));
                w.new_glyph  = (k == 0) || ($urandom_range(0, 6) == 0);
                w.target_row = 10'($urandom_range(0, 1023));
                send_code(w, 1'b0, '0);
            end
        end

        quiesce();
        $display("Sent %0d code words (%0d from the table, the rest random over %0d phases).",
                 codes_sent, directed_codes, PHASES);
        $display("Checked %0d run words after %0d register writes; %0d mismatching words.",
                 runs_checked, reg_writes, mismatches);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
